### rtl/sqdk_pkg.sv
// Shared types, codes and widths for the sorted priority queue.
package sqdk_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int ID_W = 16;
	localparam int PRIO_W = 16;
	localparam int STATUS_W = 3;
	localparam int COUNT_OUT_W = 7;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 64;

	// Commands carried by a request.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_POP = 2'd1;
	localparam logic [1:0] CMD_UPGRADE = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_UPGRADE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;

	// Operations applied to every cell in the same cycle.
	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_POP = 2'd2;
	localparam logic [1:0] OP_REMOVE = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [ID_W-1:0] id;
		logic [PRIO_W-1:0] prio;
	} cell_ctl_t;

endpackage

### rtl/sqdk_cell.sv
// One slot of the sorted queue: holds an entry and shifts it with its neighbors.
module sqdk_cell
	import sqdk_pkg::*;
(
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic              valid,
	input  logic [ID_W-1:0]   left_id,
	input  logic [PRIO_W-1:0] left_prio,
	input  logic              left_gt,
	input  logic [ID_W-1:0]   right_id,
	input  logic [PRIO_W-1:0] right_prio,
	input  logic              seen_in,
	input  logic [PRIO_W-1:0] old_in,
	output logic [ID_W-1:0]   id,
	output logic [PRIO_W-1:0] prio,
	output logic              gt,
	output logic              seen_out,
	output logic [PRIO_W-1:0] old_out,
	output logic [ID_W-1:0]   nxt_id,
	output logic [PRIO_W-1:0] nxt_prio
);

	logic [ID_W-1:0] id_q;
	logic [PRIO_W-1:0] prio_q;
	logic match;
	logic first;

	assign id = id_q;
	assign prio = prio_q;
	assign gt = valid && (prio_q > ctl.prio);
	assign match = valid && (id_q == ctl.id);
	assign first = match && !seen_in;
	assign seen_out = seen_in || match;
	assign old_out = old_in | (first ? prio_q : '0);

	always_comb begin
		nxt_id = id_q;
		nxt_prio = prio_q;
		case (ctl.op)
			OP_INSERT: begin
				// Entries behind the insertion point move back by one slot.
				if (left_gt) begin
					nxt_id = left_id;
					nxt_prio = left_prio;
				end else if (gt || !valid) begin
					nxt_id = ctl.id;
					nxt_prio = ctl.prio;
				end
			end
			OP_POP: begin
				nxt_id = right_id;
				nxt_prio = right_prio;
			end
			OP_REMOVE: begin
				if (seen_out) begin
					nxt_id = right_id;
					nxt_prio = right_prio;
				end
			end
			default: begin
				nxt_id = id_q;
				nxt_prio = prio_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		id_q <= nxt_id;
		prio_q <= nxt_prio;
	end

endmodule

### rtl/sorted_priority_queue_decrease_key.sv
// Top level of the sorted priority queue with decrease-key, built as a row of slots.
//
//  Port group  Dir  Data fields (lowest bit first)
//  s_axis      in   command[1:0], patient_id[17:2], priority_req[33:18], zero fill
//  m_axis      out  status[2:0], popped_id[18:3], head_id[34:19], head_priority[50:35],
//                   is_empty[51], entry_count[58:52], zero fill
//
// Insert, pop, clear and a rejected upgrade finish in the cycle of the request;
// an upgrade that moves its entry runs in two steps, first closing the gap in the
// slot row and then opening the new place, since each slot moves one step a cycle.
// A result that waits to be taken holds s_tready low; a new request can be taken
// in the cycle that the waiting result is taken.
// Reset empties the queue at once; slot contents are left as they are.
module sorted_priority_queue_decrease_key
	import sqdk_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // command, patient_id, priority_req
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata   // status, popped_id, head_id, head_priority,
	                                      // is_empty, entry_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic STATE_IDLE = 1'b0;
	localparam logic STATE_INS = 1'b1;

	logic [1:0] cmd;
	logic [ID_W-1:0] in_id;
	logic [PRIO_W-1:0] in_prio;
	logic accept;

	logic state_q;
	logic state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [ID_W-1:0] req_id_q;
	logic [PRIO_W-1:0] req_prio_q;
	logic m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;

	cell_ctl_t ctl;
	logic load;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0] popped;
	logic [ID_W-1:0] head_id;
	logic [PRIO_W-1:0] head_prio;
	logic is_empty;

	logic [ID_W-1:0] ids [CAPACITY];
	logic [PRIO_W-1:0] prios [CAPACITY];
	logic [ID_W-1:0] nxt_ids [CAPACITY];
	logic [PRIO_W-1:0] nxt_prios [CAPACITY];
	logic [CAPACITY-1:0] gts;
	logic [CAPACITY-1:0] valids;
	logic [CAPACITY:0] seen;
	logic [PRIO_W-1:0] olds [CAPACITY+1];

	assign cmd = s_tdata[1:0];
	assign in_id = s_tdata[17:2];
	assign in_prio = s_tdata[33:18];
	assign s_tready = (state_q == STATE_IDLE) && (!m_valid_q || m_tready);
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	assign seen[0] = 1'b0;
	assign olds[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ID_W-1:0] l_id;
		logic [PRIO_W-1:0] l_prio;
		logic l_gt;
		logic [ID_W-1:0] r_id;
		logic [PRIO_W-1:0] r_prio;

		assign valids[i] = CNT_W'(i) < count_q;

		if (i == 0) begin : g_first
			assign l_id = ctl.id;
			assign l_prio = ctl.prio;
			assign l_gt = 1'b0;
		end else begin : g_mid
			assign l_id = ids[i-1];
			assign l_prio = prios[i-1];
			assign l_gt = gts[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_id = ids[i];
			assign r_prio = prios[i];
		end else begin : g_body
			assign r_id = ids[i+1];
			assign r_prio = prios[i+1];
		end

		sqdk_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.valid     (valids[i]),
			.left_id   (l_id),
			.left_prio (l_prio),
			.left_gt   (l_gt),
			.right_id  (r_id),
			.right_prio(r_prio),
			.seen_in   (seen[i]),
			.old_in    (olds[i]),
			.id        (ids[i]),
			.prio      (prios[i]),
			.gt        (gts[i]),
			.seen_out  (seen[i+1]),
			.old_out   (olds[i+1]),
			.nxt_id    (nxt_ids[i]),
			.nxt_prio  (nxt_prios[i])
		);
	end

	always_comb begin
		ctl.op = OP_HOLD;
		ctl.id = in_id;
		ctl.prio = in_prio;
		count_d = count_q;
		state_d = state_q;
		status = ST_OK;
		popped = '0;
		load = 1'b0;
		if (state_q == STATE_INS) begin
			// Second half of an upgrade: place the entry at its new position.
			ctl.op = OP_INSERT;
			ctl.id = req_id_q;
			ctl.prio = req_prio_q;
			count_d = count_q + 1'b1;
			state_d = STATE_IDLE;
			load = 1'b1;
		end else if (accept) begin
			load = 1'b1;
			case (cmd)
				CMD_INSERT: begin
					if (count_q == CNT_W'(CAPACITY)) begin
						status = ST_FULL;
					end else begin
						ctl.op = OP_INSERT;
						count_d = count_q + 1'b1;
					end
				end
				CMD_POP: begin
					if (count_q == '0) begin
						status = ST_EMPTY;
					end else begin
						ctl.op = OP_POP;
						popped = ids[0];
						count_d = count_q - 1'b1;
					end
				end
				CMD_UPGRADE: begin
					if (count_q == '0) begin
						status = ST_EMPTY;
					end else if (!seen[CAPACITY]) begin
						status = ST_NOT_FOUND;
					end else if (olds[CAPACITY] <= in_prio) begin
						status = ST_NOT_UPGRADE;
					end else begin
						// Take the entry out now; the result follows the reinsert.
						ctl.op = OP_REMOVE;
						count_d = count_q - 1'b1;
						state_d = STATE_INS;
						load = 1'b0;
					end
				end
				default: begin
					count_d = '0;
				end
			endcase
		end
	end

	assign is_empty = (count_d == '0);
	assign head_id = is_empty ? '0 : nxt_ids[0];
	assign head_prio = is_empty ? '0 : nxt_prios[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_IDLE;
			count_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_id_q <= in_id;
			req_prio_q <= in_prio;
		end
		if (load) begin
			m_data_q <= {5'b0, COUNT_OUT_W'(count_d), is_empty, head_prio, head_id,
				popped, status};
		end
	end

endmodule
